/* rtl/csis_pkg.sv */
// ----------------------------------------------------------------------------
// csis_pkg
// Types and character codes shared by the C source identifier scanner.
// ----------------------------------------------------------------------------
package csis_pkg;

    typedef enum logic [3:0] {
        MODE_TOP      = 4'd0,
        MODE_STR      = 4'd1,
        MODE_STR_ESC  = 4'd2,
        MODE_SLASH    = 4'd3,
        MODE_CMT      = 4'd4,
        MODE_CMT_STAR = 4'd5,
        MODE_IDENT    = 4'd6,
        MODE_DEC      = 4'd7,
        MODE_FRAC     = 4'd8,
        MODE_EXP      = 4'd9,
        MODE_EXP_SIGN = 4'd10,
        MODE_EXP_DIG  = 4'd11,
        MODE_ZERO     = 4'd12,
        MODE_HEX      = 4'd13,
        MODE_OCT      = 4'd14
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [7:0]  len;
        logic        ovf;
        logic        last;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

    typedef struct packed {
        mode_t      mode;
        logic       quote_dbl;
        logic [7:0] count;
        logic       too_long;
    } scan_state_t;

    localparam scan_state_t STATE_RESET = '{MODE_TOP, 1'b0, 8'd0, 1'b0};

    localparam logic [0:0] REG_COPY_MODE = 1'b0;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_UNDER);
    endfunction

endpackage

/* rtl/c_source_identifier_scanner.sv */
// ----------------------------------------------------------------------------
// c_source_identifier_scanner
// Streams C source bytes and reports identifiers, optionally echoing the
// rest of the text.
//
// Input words (s_source_byte, s_end_of_file) enter a one-word input register
// and are scanned one per cycle by the lexical state machine. Each word
// yields zero, one or two result words (echoed byte, identifier character,
// identifier end marker with length and overflow); m_last_of_run marks the
// final result word of an input word. Results pass from the input register
// into a four-word queue and are offered from there; one input word per
// cycle is sustained while each yields at most one result and m_ready stays
// high. A stalled receiver fills the queue; the scanner then holds the input
// register and drops s_ready. Reset returns the scanner to top level, empties
// the queue and clears copy_mode. copy_mode is written through the APB port
// at address 0; the user must do so only while the stream is idle, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module c_source_identifier_scanner #(
    parameter int unsigned MAX_IDENT_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_item_kind,
    output logic [7:0]  m_out_byte,
    output logic [7:0]  m_ident_length,
    output logic        m_ident_overflow,
    output logic        m_last_of_run
);

    localparam int unsigned KEEP_LIMIT = (MAX_IDENT_LEN - 1 > 255) ? 255 : MAX_IDENT_LEN - 1;

    logic                  copy_mode_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_eof_reg;
    csis_pkg::scan_state_t state_reg;
    csis_pkg::scan_state_t state_next;
    csis_pkg::push_t       push;
    csis_pkg::res_t        rd_data;
    logic                  room;
    logic                  advance;

    assign pready  = 1'b1;
    assign prdata  = {31'd0, copy_mode_reg};
    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr == {1'b0, csis_pkg::REG_COPY_MODE}) begin
            copy_mode_reg <= pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= csis_pkg::STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_source_byte;
            in_eof_reg  <= s_end_of_file;
        end
    end

    csis_step #(
        .KEEP_LIMIT(KEEP_LIMIT)
    ) u_step (
        .copy_mode(copy_mode_reg),
        .c        (in_byte_reg),
        .eof      (in_eof_reg),
        .st       (state_reg),
        .st_next  (state_next),
        .push     (push)
    );

    csis_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (advance),
        .push    (push),
        .room    (room),
        .rd_valid(m_valid),
        .rd_ready(m_ready),
        .rd_data (rd_data)
    );

    assign m_item_kind      = rd_data.kind;
    assign m_out_byte       = rd_data.data;
    assign m_ident_length   = rd_data.len;
    assign m_ident_overflow = rd_data.ovf;
    assign m_last_of_run    = rd_data.last;

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count <= KEEP_LIMIT[7:0])
        else $error("identifier count above limit");

    a_eof_to_top: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_eof_reg |=> state_reg == csis_pkg::STATE_RESET)
        else $error("end of file did not return scanner to top level");

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && push.v1 |-> push.v0 && push.r0.kind == csis_pkg::KIND_END
            || advance && push.v1 && copy_mode_reg)
        else $error("two results without end marker or echo");

endmodule

/* rtl/csis_step.sv */
// ----------------------------------------------------------------------------
// csis_step
// Lexical state transition for one source byte: next scanner state and up
// to two result words.
// ----------------------------------------------------------------------------
module csis_step #(
    parameter int unsigned KEEP_LIMIT = 255
) (
    input  logic                  copy_mode,
    input  logic [7:0]            c,
    input  logic                  eof,
    input  csis_pkg::scan_state_t st,
    output csis_pkg::scan_state_t st_next,
    output csis_pkg::push_t       push
);

    localparam logic [7:0] LIMIT = KEEP_LIMIT[7:0];

    csis_pkg::scan_state_t mid;
    csis_pkg::res_t        a;
    csis_pkg::res_t        b;
    logic                  a_v;
    logic                  b_v;
    logic                  go_top;
    logic                  is_id;

    always_comb begin
        mid    = st;
        a      = '{csis_pkg::KIND_ECHO, c, 8'd0, 1'b0, 1'b0};
        a_v    = 1'b0;
        go_top = 1'b0;
        is_id  = csis_pkg::is_id_start(c) || csis_pkg::is_dec(c);

        if (eof) begin
            if (st.mode == csis_pkg::MODE_IDENT) begin
                a   = '{csis_pkg::KIND_END, 8'd0, st.count, st.too_long, 1'b0};
                a_v = 1'b1;
            end
            mid = csis_pkg::STATE_RESET;
        end else begin
            unique case (st.mode)
                csis_pkg::MODE_STR: begin
                    a_v = copy_mode;
                    if (c == (st.quote_dbl ? csis_pkg::CH_DQUOTE : csis_pkg::CH_SQUOTE)) begin
                        mid.mode = csis_pkg::MODE_TOP;
                    end else if (c == csis_pkg::CH_BSLASH) begin
                        mid.mode = csis_pkg::MODE_STR_ESC;
                    end
                end
                csis_pkg::MODE_STR_ESC: begin
                    a_v      = copy_mode;
                    mid.mode = csis_pkg::MODE_STR;
                end
                csis_pkg::MODE_SLASH: begin
                    if (c == csis_pkg::CH_STAR) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_CMT;
                    end else begin
                        go_top = 1'b1;
                    end
                end
                csis_pkg::MODE_CMT, csis_pkg::MODE_CMT_STAR: begin
                    a_v = copy_mode;
                    if (st.mode == csis_pkg::MODE_CMT_STAR && c == csis_pkg::CH_SLASH) begin
                        mid.mode = csis_pkg::MODE_TOP;
                    end else if (c == csis_pkg::CH_STAR) begin
                        mid.mode = csis_pkg::MODE_CMT_STAR;
                    end else begin
                        mid.mode = csis_pkg::MODE_CMT;
                    end
                end
                csis_pkg::MODE_IDENT: begin
                    if (is_id) begin
                        if (st.count < LIMIT) begin
                            mid.count = st.count + 8'd1;
                            a.kind    = csis_pkg::KIND_CHAR;
                            a_v       = 1'b1;
                        end else begin
                            mid.too_long = 1'b1;
                        end
                    end else begin
                        a            = '{csis_pkg::KIND_END, 8'd0, st.count, st.too_long, 1'b0};
                        a_v          = 1'b1;
                        mid.count    = 8'd0;
                        mid.too_long = 1'b0;
                        go_top       = 1'b1;
                    end
                end
                csis_pkg::MODE_DEC: begin
                    if (c == csis_pkg::CH_DOT) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_FRAC;
                    end else if (c == csis_pkg::CH_LE) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_EXP;
                    end else if (csis_pkg::is_dec(c)) begin
                        a_v = copy_mode;
                    end else begin
                        go_top = 1'b1;
                    end
                end
                csis_pkg::MODE_FRAC: begin
                    if (c == csis_pkg::CH_LE) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_EXP;
                    end else if (csis_pkg::is_dec(c)) begin
                        a_v = copy_mode;
                    end else begin
                        go_top = 1'b1;
                    end
                end
                csis_pkg::MODE_EXP: begin
                    if (c == csis_pkg::CH_PLUS || c == csis_pkg::CH_MINUS) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_EXP_SIGN;
                    end else if (csis_pkg::is_dec(c)) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_EXP_DIG;
                    end else begin
                        go_top = 1'b1;
                    end
                end
                csis_pkg::MODE_EXP_SIGN: begin
                    if (csis_pkg::is_dec(c)) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_EXP_DIG;
                    end else begin
                        go_top = 1'b1;
                    end
                end
                csis_pkg::MODE_EXP_DIG: begin
                    a_v    = copy_mode && csis_pkg::is_dec(c);
                    go_top = !csis_pkg::is_dec(c);
                end
                csis_pkg::MODE_ZERO: begin
                    if (c == csis_pkg::CH_LX || c == csis_pkg::CH_UX) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_HEX;
                    end else if (csis_pkg::is_oct(c)) begin
                        a_v      = copy_mode;
                        mid.mode = csis_pkg::MODE_OCT;
                    end else begin
                        go_top = 1'b1;
                    end
                end
                csis_pkg::MODE_HEX: begin
                    a_v    = copy_mode && csis_pkg::is_hex(c);
                    go_top = !csis_pkg::is_hex(c);
                end
                csis_pkg::MODE_OCT: begin
                    a_v    = copy_mode && csis_pkg::is_oct(c);
                    go_top = !csis_pkg::is_oct(c);
                end
                default: begin
                    go_top = 1'b1;
                end
            endcase
        end

        // rescan at top level
        st_next = mid;
        b       = '{csis_pkg::KIND_ECHO, c, 8'd0, 1'b0, 1'b0};
        b_v     = 1'b0;
        if (go_top) begin
            st_next.mode = csis_pkg::MODE_TOP;
            b_v          = copy_mode;
            if (c == csis_pkg::CH_DQUOTE || c == csis_pkg::CH_SQUOTE) begin
                st_next.quote_dbl = (c == csis_pkg::CH_DQUOTE);
                st_next.mode      = csis_pkg::MODE_STR;
            end else if (c == csis_pkg::CH_SLASH) begin
                st_next.mode = csis_pkg::MODE_SLASH;
            end else if (csis_pkg::is_id_start(c)) begin
                st_next.too_long = 1'b0;
                st_next.count    = 8'd1;
                st_next.mode     = csis_pkg::MODE_IDENT;
                b.kind           = csis_pkg::KIND_CHAR;
                b_v              = 1'b1;
            end else if (csis_pkg::is_dec(c)) begin
                st_next.mode = (c == csis_pkg::CH_0) ? csis_pkg::MODE_ZERO
                                                      : csis_pkg::MODE_DEC;
            end
        end

        push.v0      = a_v || b_v;
        push.v1      = a_v && b_v;
        push.r0      = a_v ? a : b;
        push.r0.last = !(a_v && b_v);
        push.r1      = b;
        push.r1.last = 1'b1;
    end

endmodule

/* rtl/csis_out_fifo.sv */
// ----------------------------------------------------------------------------
// csis_out_fifo
// Four-word result queue; takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
module csis_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  csis_pkg::push_t push,
    output logic            room,
    output logic            rd_valid,
    input  logic            rd_ready,
    output csis_pkg::res_t  rd_data
);

    csis_pkg::res_t mem_reg [4];
    logic [1:0]     wr_ptr_reg;
    logic [1:0]     rd_ptr_reg;
    logic [2:0]     count_reg;
    logic [1:0]     wr_ptr_next;
    logic [1:0]     rd_ptr_next;
    logic [2:0]     count_next;
    logic           pop;
    logic [1:0]     n_push;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (count_reg != 3'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign room     = (count_reg <= 3'd2);

    always_comb begin
        n_push      = wr_en ? ({1'b0, push.v0} + {1'b0, push.v1}) : 2'd0;
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && push.v0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (wr_en && push.v1) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

endmodule

/* tb/sv/tb_c_source_identifier_scanner.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_source_identifier_scanner
// Self-checking bench for the C source identifier scanner. A directed burst
// walks strings, escapes, comments, every number form and end of file, then
// random well-formed C fragments mixed with noise run under both copy modes.
// A lexer mirror predicts every result word and checks each one as it leaves
// the block, with random stalls, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_c_source_identifier_scanner;

    localparam int IDENT_CAP   = 256;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_WORDS = 300;

    class lexer_mirror;
        bit              copy_on;
        csis_pkg::mode_t mode;
        bit              quote_dbl;
        bit [7:0]        kept;
        bit              too_long;
        int              keep_max;
        int              faults;
        csis_pkg::res_t  owed[$];
        csis_pkg::res_t  burst[$];

        function new(int ident_cap);
            keep_max = (ident_cap - 1 > 255) ? 255 : ident_cap - 1;
            copy_on  = 1'b0;
            faults   = 0;
            restart();
        endfunction

        function void restart();
            mode      = csis_pkg::MODE_TOP;
            quote_dbl = 1'b0;
            kept      = 8'd0;
            too_long  = 1'b0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= csis_pkg::CH_0 && c <= csis_pkg::CH_9;
        endfunction

        function bit is_octal(logic [7:0] c);
            return c >= csis_pkg::CH_0 && c <= csis_pkg::CH_7;
        endfunction

        function bit is_hexdig(logic [7:0] c);
            return is_digit(c) || (c >= csis_pkg::CH_LA && c <= csis_pkg::CH_LF)
                || (c >= csis_pkg::CH_UA && c <= csis_pkg::CH_UF);
        endfunction

        function bit starts_word(logic [7:0] c);
            return (c >= csis_pkg::CH_LA && c <= csis_pkg::CH_LZ)
                || (c >= csis_pkg::CH_UA && c <= csis_pkg::CH_UZ) || c == csis_pkg::CH_UNDER;
        endfunction

        function bit in_word(logic [7:0] c);
            return starts_word(c) || is_digit(c);
        endfunction

        function void put(csis_pkg::kind_t k, logic [7:0] d, logic [7:0] n, logic o);
            csis_pkg::res_t r;
            r.kind = k;
            r.data = d;
            r.len  = n;
            r.ovf  = o;
            r.last = 1'b0;
            burst.push_back(r);
        endfunction

        function void echo(logic [7:0] c);
            if (copy_on) put(csis_pkg::KIND_ECHO, c, 8'd0, 1'b0);
        endfunction

        function void at_top(logic [7:0] c);
            if (c == csis_pkg::CH_DQUOTE || c == csis_pkg::CH_SQUOTE) begin
                echo(c);
                quote_dbl = (c == csis_pkg::CH_DQUOTE);
                mode = csis_pkg::MODE_STR;
            end else if (c == csis_pkg::CH_SLASH) begin
                echo(c);
                mode = csis_pkg::MODE_SLASH;
            end else if (starts_word(c)) begin
                too_long = 1'b0;
                kept = 8'd1;
                put(csis_pkg::KIND_CHAR, c, 8'd0, 1'b0);
                mode = csis_pkg::MODE_IDENT;
            end else if (is_digit(c)) begin
                echo(c);
                mode = (c == csis_pkg::CH_0) ? csis_pkg::MODE_ZERO : csis_pkg::MODE_DEC;
            end else begin
                echo(c);
            end
        endfunction

        function void comment_byte(logic [7:0] c);
            echo(c);
            mode = (c == csis_pkg::CH_STAR) ? csis_pkg::MODE_CMT_STAR : csis_pkg::MODE_CMT;
        endfunction

        // stay in the number on an accepted digit, else rescan at top level
        function void digit_run(logic [7:0] c, bit ok);
            if (ok) begin
                echo(c);
            end else begin
                mode = csis_pkg::MODE_TOP;
                at_top(c);
            end
        endfunction

        function void scan_byte(logic [7:0] c);
            case (mode)
                csis_pkg::MODE_STR: begin
                    echo(c);
                    if (c == (quote_dbl ? csis_pkg::CH_DQUOTE : csis_pkg::CH_SQUOTE)) begin
                        mode = csis_pkg::MODE_TOP;
                    end else if (c == csis_pkg::CH_BSLASH) begin
                        mode = csis_pkg::MODE_STR_ESC;
                    end
                end
                csis_pkg::MODE_STR_ESC: begin
                    echo(c);
                    mode = csis_pkg::MODE_STR;
                end
                csis_pkg::MODE_SLASH: begin
                    if (c == csis_pkg::CH_STAR) begin
                        echo(c);
                        mode = csis_pkg::MODE_CMT;
                    end else begin
                        mode = csis_pkg::MODE_TOP;
                        at_top(c);
                    end
                end
                csis_pkg::MODE_CMT: comment_byte(c);
                csis_pkg::MODE_CMT_STAR: begin
                    if (c == csis_pkg::CH_SLASH) begin
                        echo(c);
                        mode = csis_pkg::MODE_TOP;
                    end else begin
                        comment_byte(c);
                    end
                end
                csis_pkg::MODE_IDENT: begin
                    if (in_word(c)) begin
                        if (kept < keep_max) begin
                            kept++;
                            put(csis_pkg::KIND_CHAR, c, 8'd0, 1'b0);
                        end else begin
                            too_long = 1'b1;
                        end
                    end else begin
                        put(csis_pkg::KIND_END, 8'd0, kept, too_long);
                        kept = 8'd0;
                        too_long = 1'b0;
                        mode = csis_pkg::MODE_TOP;
                        at_top(c);
                    end
                end
                csis_pkg::MODE_DEC: begin
                    if (c == csis_pkg::CH_DOT) begin
                        echo(c);
                        mode = csis_pkg::MODE_FRAC;
                    end else if (c == csis_pkg::CH_LE) begin
                        echo(c);
                        mode = csis_pkg::MODE_EXP;
                    end else begin
                        digit_run(c, is_digit(c));
                    end
                end
                csis_pkg::MODE_FRAC: begin
                    if (c == csis_pkg::CH_LE) begin
                        echo(c);
                        mode = csis_pkg::MODE_EXP;
                    end else begin
                        digit_run(c, is_digit(c));
                    end
                end
                csis_pkg::MODE_EXP: begin
                    if (c == csis_pkg::CH_PLUS || c == csis_pkg::CH_MINUS) begin
                        echo(c);
                        mode = csis_pkg::MODE_EXP_SIGN;
                    end else if (is_digit(c)) begin
                        echo(c);
                        mode = csis_pkg::MODE_EXP_DIG;
                    end else begin
                        digit_run(c, 1'b0);
                    end
                end
                csis_pkg::MODE_EXP_SIGN: begin
                    if (is_digit(c)) begin
                        echo(c);
                        mode = csis_pkg::MODE_EXP_DIG;
                    end else begin
                        digit_run(c, 1'b0);
                    end
                end
                csis_pkg::MODE_EXP_DIG: digit_run(c, is_digit(c));
                csis_pkg::MODE_ZERO: begin
                    if (c == csis_pkg::CH_LX || c == csis_pkg::CH_UX) begin
                        echo(c);
                        mode = csis_pkg::MODE_HEX;
                    end else if (is_octal(c)) begin
                        echo(c);
                        mode = csis_pkg::MODE_OCT;
                    end else begin
                        digit_run(c, 1'b0);
                    end
                end
                csis_pkg::MODE_HEX: digit_run(c, is_hexdig(c));
                csis_pkg::MODE_OCT: digit_run(c, is_octal(c));
                default: begin
                    mode = csis_pkg::MODE_TOP;
                    at_top(c);
                end
            endcase
        endfunction

        function void absorb(logic [7:0] c, logic eof);
            burst.delete();
            if (eof) begin
                if (mode == csis_pkg::MODE_IDENT) put(csis_pkg::KIND_END, 8'd0, kept, too_long);
                restart();
            end else begin
                scan_byte(c);
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) owed.push_back(burst[i]);
        endfunction

        function void compare(logic [1:0] kind, logic [7:0] data, logic [7:0] len,
                              logic ovf, logic last);
            csis_pkg::res_t want;
            if (owed.size() == 0) begin
                $error("unexpected result word: item_kind %0d out_byte %02h", kind, data);
                faults++;
                return;
            end
            want = owed.pop_front();
            if (kind !== want.kind) begin
                $error("item_kind: expected %0d, actual %0d", want.kind, kind);
                faults++;
            end
            if (data !== want.data) begin
                $error("out_byte: expected %02h, actual %02h", want.data, data);
                faults++;
            end
            if (len !== want.len) begin
                $error("ident_length: expected %0d, actual %0d", want.len, len);
                faults++;
            end
            if (ovf !== want.ovf) begin
                $error("ident_overflow: expected %0b, actual %0b", want.ovf, ovf);
                faults++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0b, actual %0b", want.last, last);
                faults++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_source_byte;
    logic        s_end_of_file;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_item_kind;
    logic [7:0]  m_out_byte;
    logic [7:0]  m_ident_length;
    logic        m_ident_overflow;
    logic        m_last_of_run;

    lexer_mirror mirror;
    bit tx_jitter = 1'b1;
    bit rx_jitter = 1'b1;
    int hold_left = 0;
    int stall_left = 0;
    int sent = 0;
    int quiet = 0;

    always #1 aclk = ~aclk;

    c_source_identifier_scanner #(
        .MAX_IDENT_LEN(IDENT_CAP)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_source_byte(s_source_byte),
        .s_end_of_file(s_end_of_file),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item_kind(m_item_kind),
        .m_out_byte(m_out_byte),
        .m_ident_length(m_ident_length),
        .m_ident_overflow(m_ident_overflow),
        .m_last_of_run(m_last_of_run)
    );

    function automatic logic [7:0] pick_word_start();
        int n;
        n = $urandom_range(0, 52);
        if (n < 26) return 8'(csis_pkg::CH_LA + n);
        if (n < 52) return 8'(csis_pkg::CH_UA + n - 26);
        return csis_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_word_char();
        if ($urandom_range(0, 5) == 0) return 8'(csis_pkg::CH_0 + $urandom_range(0, 9));
        return pick_word_start();
    endfunction

    function automatic logic [7:0] pick_hex();
        int n;
        n = $urandom_range(0, 21);
        if (n < 10) return 8'(csis_pkg::CH_0 + n);
        if (n < 16) return 8'(csis_pkg::CH_LA + n - 10);
        return 8'(csis_pkg::CH_UA + n - 16);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eof = 1'b0);
        if (tx_jitter && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_source_byte <= b;
        s_end_of_file <= eof;
        do @(posedge aclk); while (!s_ready);
        mirror.absorb(b, eof);
        sent++;
    endtask

    task automatic settle_stream();
        s_valid <= 1'b0;
        while (mirror.owed.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic program_copy(input logic value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'(4 * csis_pkg::REG_COPY_MODE);
        pwdata <= {31'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mirror.copy_on = value;
    endtask

    task automatic send_fragment();
        int n;
        logic [7:0] q;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 300)
                                                 : $urandom_range(1, 12);
                send_word(pick_word_start());
                repeat (n - 1) send_word(pick_word_char());
            end
            3: begin
                send_word(8'(csis_pkg::CH_0 + $urandom_range(1, 9)));
                repeat ($urandom_range(0, 3)) begin
                    send_word(8'(csis_pkg::CH_0 + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 1)) begin
                    send_word(csis_pkg::CH_DOT);
                    repeat ($urandom_range(0, 2)) begin
                        send_word(8'(csis_pkg::CH_0 + $urandom_range(0, 9)));
                    end
                end
                if ($urandom_range(0, 1)) begin
                    send_word(csis_pkg::CH_LE);
                    case ($urandom_range(0, 2))
                        0: send_word(csis_pkg::CH_PLUS);
                        1: send_word(csis_pkg::CH_MINUS);
                        default: ;
                    endcase
                    repeat ($urandom_range(0, 2)) begin
                        send_word(8'(csis_pkg::CH_0 + $urandom_range(0, 9)));
                    end
                end
            end
            4: begin
                send_word(csis_pkg::CH_0);
                send_word($urandom_range(0, 1) ? csis_pkg::CH_LX : csis_pkg::CH_UX);
                repeat ($urandom_range(0, 4)) send_word(pick_hex());
            end
            5: begin
                send_word(csis_pkg::CH_0);
                repeat ($urandom_range(0, 4)) begin
                    send_word(8'(csis_pkg::CH_0 + $urandom_range(0, 7)));
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_word(8'(csis_pkg::CH_0 + $urandom_range(8, 9)));
                end
            end
            6: begin
                q = $urandom_range(0, 1) ? csis_pkg::CH_DQUOTE : csis_pkg::CH_SQUOTE;
                send_word(q);
                repeat ($urandom_range(0, 8)) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            send_word(csis_pkg::CH_BSLASH);
                            send_word(8'($urandom_range(0, 255)));
                        end
                        1: send_word(q == csis_pkg::CH_DQUOTE ? csis_pkg::CH_SQUOTE
                                                               : csis_pkg::CH_DQUOTE);
                        2: send_word(8'($urandom_range(0, 255)));
                        default: send_word(8'($urandom_range(32, 126)));
                    endcase
                end
                if ($urandom_range(0, 7) != 0) send_word(q);
            end
            7: begin
                send_word(csis_pkg::CH_SLASH);
                send_word(csis_pkg::CH_STAR);
                repeat ($urandom_range(0, 8)) begin
                    send_word($urandom_range(0, 2) == 0 ? csis_pkg::CH_STAR
                                                        : 8'($urandom_range(32, 126)));
                end
                send_word(csis_pkg::CH_STAR);
                send_word(csis_pkg::CH_SLASH);
            end
            8: begin
                send_word(csis_pkg::CH_SLASH);
                send_word(8'($urandom_range(0, 255)));
            end
            9: send_word($urandom_range(0, 3) == 0 ? 8'h0A : 8'($urandom_range(32, 47)));
            10: repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)));
            default: begin
                if ($urandom_range(0, 1)) send_word(8'($urandom_range(0, 255)), 1'b1);
                else send_word(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // receiver: random stall bursts plus a long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (rx_jitter && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            mirror.compare(m_item_kind, m_out_byte, m_ident_length, m_ident_overflow,
                           m_last_of_run);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        string warmup;
        int target;
        bit held;
        warmup = "z_9\"\\\"\"/**a*/0xF 5.e+;07/k'\\'";
        held = 1'b0;
        mirror = new(IDENT_CAP);
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 2'd0;
        pwdata <= 32'd0;
        s_valid <= 1'b0;
        s_source_byte <= 8'd0;
        s_end_of_file <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        program_copy(1'b1);
        for (int i = 0; i < warmup.len(); i++) send_word(warmup[i]);
        send_word(8'hFF);
        send_word(8'h00);
        send_word(8'h5A, 1'b1);
        send_word(csis_pkg::CH_UNDER);
        send_word(csis_pkg::CH_LA);
        send_word(8'hA5, 1'b1);
        send_word(8'h00, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            settle_stream();
            program_copy(phase[0]);
            if (phase == 3) begin
                tx_jitter = 1'b0;
                rx_jitter = 1'b0;
            end
            target = sent + PHASE_WORDS;
            while (sent < target) begin
                // hold the receiver off so the queue fills and the input stalls
                if (phase == 1 && !held && sent >= target - 200) begin
                    hold_left = 80;
                    held = 1'b1;
                end
                send_fragment();
            end
        end

        settle_stream();
        if (mirror.faults == 0 && mirror.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
